// ===== hw/rtl/address_blocklist_table_defines.svh =====
// Assertion macros shared by the blocked-address table RTL.
`ifndef ADDRESS_BLOCKLIST_TABLE_DEFINES_SVH
`define ADDRESS_BLOCKLIST_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clk_i edge outside reset.
`define ABT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("blocklist table assertion failed");
// Check that a condition never holds outside reset.
`define ABT_ASSERT_NEVER(lbl, expr) `ABT_ASSERT(lbl, !(expr))
`else
`define ABT_ASSERT(lbl, prop)
`define ABT_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/abt_pkg.sv =====
// Types and constants of the blocked-address table.
package abt_pkg;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned HIT_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned ECNT_W   = 8;
  localparam int unsigned ENTRY_W  = ADDR_W + HIT_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_BLOCK   = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_UNBLOCK = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_REFUSED   = 3'd6
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [HIT_W-1:0]  hits;
    logic              lock;
  } entry_t;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic              perm;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [HIT_W-1:0]  hits;
    logic [ECNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/abt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module abt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/abt_seq.sv =====
// Request sequencer: scans, updates and compacts the table one entry per cycle.
`include "address_blocklist_table_defines.svh"

module abt_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  abt_pkg::req_t                 req_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output abt_pkg::res_t                 res_o,
  output abt_pkg::ram_req_t             ram_o,
  input  logic [abt_pkg::ENTRY_W-1:0]   ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                              state_q, state_d;
  abt_pkg::op_e                        op_q, op_d;
  logic [abt_pkg::ADDR_W-1:0]          addr_q, addr_d;
  logic                                perm_q, perm_d;
  logic [abt_pkg::CNT_W-1:0]           count_q, count_d;
  logic [abt_pkg::IDX_W-1:0]           idx_q, idx_d;
  abt_pkg::status_e                    status_q, status_d;
  logic [abt_pkg::SLOT_W-1:0]          slot_q, slot_d;
  logic [abt_pkg::HIT_W-1:0]           hits_q, hits_d;

  abt_pkg::entry_t                     rd_entry;
  abt_pkg::op_e                        cur_op;
  logic [abt_pkg::ADDR_W-1:0]          cur_addr;
  logic                                cur_perm;
  logic [abt_pkg::HIT_W-1:0]           bumped;
  logic                                last_idx;
  logic                                full;
  logic                                miss;

  assign rd_entry = abt_pkg::entry_t'(ram_rdata_i);
  assign cur_op   = (state_q == S_IDLE) ? req_i.op   : op_q;
  assign cur_addr = (state_q == S_IDLE) ? req_i.addr : addr_q;
  assign cur_perm = (state_q == S_IDLE) ? req_i.perm : perm_q;
  assign bumped   = (rd_entry.hits == '1) ? rd_entry.hits
                                          : rd_entry.hits + abt_pkg::HIT_W'(1);
  assign last_idx = (abt_pkg::CNT_W'(idx_q) + abt_pkg::CNT_W'(1)) == count_q;
  assign full     = count_q == abt_pkg::CNT_W'(abt_pkg::TABLE_DEPTH);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    addr_d   = addr_q;
    perm_d   = perm_q;
    count_d  = count_q;
    idx_d    = idx_q;
    status_d = status_q;
    slot_d   = slot_q;
    hits_d   = hits_q;
    miss     = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = idx_q;
    ram_o.wdata = rd_entry;
    ram_o.re    = 1'b0;
    ram_o.raddr = idx_q + abt_pkg::IDX_W'(1);

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d   = req_i.op;
          addr_d = req_i.addr;
          perm_d = req_i.perm;
          if (count_q == '0 || req_i.op == abt_pkg::OP_NONE) begin
            miss = 1'b1;
          end else begin
            // start the scan at entry zero
            ram_o.re    = 1'b1;
            ram_o.raddr = '0;
            idx_d       = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_entry.addr == addr_q) begin
          slot_d  = abt_pkg::SLOT_W'(idx_q);
          state_d = S_DONE;
          case (op_q)
            abt_pkg::OP_BLOCK, abt_pkg::OP_LOOKUP: begin
              ram_o.we         = 1'b1;
              ram_o.wdata.hits = bumped;
              hits_d           = bumped;
              status_d         = (op_q == abt_pkg::OP_BLOCK) ? abt_pkg::ST_PRESENT
                                                             : abt_pkg::ST_FOUND;
            end
            abt_pkg::OP_UNBLOCK: begin
              hits_d = rd_entry.hits;
              if (rd_entry.lock) begin
                status_d = abt_pkg::ST_REFUSED;
              end else begin
                status_d = abt_pkg::ST_REMOVED;
                if (last_idx) begin
                  count_d = count_q - abt_pkg::CNT_W'(1);
                end else begin
                  // pull the next entry down over the removed one
                  ram_o.re = 1'b1;
                  idx_d    = idx_q + abt_pkg::IDX_W'(1);
                  state_d  = S_SHIFT;
                end
              end
            end
            default: begin
              status_d = abt_pkg::ST_NOT_FOUND;
              slot_d   = '0;
              hits_d   = '0;
            end
          endcase
        end else if (last_idx) begin
          miss = 1'b1;
        end else begin
          ram_o.re = 1'b1;
          idx_d    = idx_q + abt_pkg::IDX_W'(1);
        end
      end
      S_SHIFT: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q - abt_pkg::IDX_W'(1);
        if (last_idx) begin
          count_d = count_q - abt_pkg::CNT_W'(1);
          state_d = S_DONE;
        end else begin
          ram_o.re = 1'b1;
          idx_d    = idx_q + abt_pkg::IDX_W'(1);
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (miss) begin
      state_d  = S_DONE;
      slot_d   = '0;
      hits_d   = '0;
      status_d = abt_pkg::ST_NOT_FOUND;
      if (cur_op == abt_pkg::OP_BLOCK) begin
        if (full) begin
          status_d = abt_pkg::ST_FULL;
        end else begin
          // append at the end of the list
          ram_o.we         = 1'b1;
          ram_o.waddr      = abt_pkg::IDX_W'(count_q);
          ram_o.wdata.addr = cur_addr;
          ram_o.wdata.hits = abt_pkg::HIT_W'(1);
          ram_o.wdata.lock = cur_perm;
          count_d          = count_q + abt_pkg::CNT_W'(1);
          status_d         = abt_pkg::ST_INSERTED;
          slot_d           = abt_pkg::SLOT_W'(count_q);
          hits_d           = abt_pkg::HIT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= abt_pkg::OP_NONE;
      addr_q   <= '0;
      perm_q   <= 1'b0;
      count_q  <= '0;
      idx_q    <= '0;
      status_q <= abt_pkg::ST_NOT_FOUND;
      slot_q   <= '0;
      hits_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      addr_q   <= addr_d;
      perm_q   <= perm_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      slot_q   <= slot_d;
      hits_q   <= hits_d;
    end
  end

  assign req_ready_o       = state_q == S_IDLE;
  assign res_valid_o       = state_q == S_DONE;
  assign res_o.status      = status_q;
  assign res_o.slot        = slot_q;
  assign res_o.hits        = hits_q;
  assign res_o.entry_count = abt_pkg::ECNT_W'(count_q);

  // The count moves by at most one per cycle: difference plus one lies in 0..2.
  `ABT_ASSERT_NEVER(a_count_bound, count_q > abt_pkg::CNT_W'(abt_pkg::TABLE_DEPTH))
  `ABT_ASSERT(a_count_step, (count_q - $past(count_q) + abt_pkg::CNT_W'(1)) <= abt_pkg::CNT_W'(2))
  `ABT_ASSERT(a_count_done, (count_d != count_q) |=> (state_q == S_DONE))
  `ABT_ASSERT_NEVER(a_rw_clash, ram_o.we && ram_o.re && (ram_o.waddr == ram_o.raddr))

endmodule

// ===== hw/rtl/address_blocklist_table.sv =====
// Top level of the blocked-address table: table RAM, sequencer and result register.
//
// Keeps an ordered list of up to TABLE_DEPTH blocked IPv4 addresses, each
// with a saturating 32-bit hit count and a permanent flag, in one RAM word
// per entry. A request (block, look up, unblock) is taken when
// in_valid_i and in_ready_o are both high; in_ready_o is high only while no
// request is in progress. The sequencer reads the table through the single
// RAM read port, one entry per cycle, from position 0 until the first match
// or the last valid entry; a match is updated in the cycle it is seen. An
// unblock then moves every later entry down one position, again one entry
// per cycle. A request on an empty table or with the unused operation code
// reads nothing and goes straight to its result; any other request scans
// up to its match or through every valid entry, and an unblock that
// removes an entry then shifts all later ones. in_ready_o rises in the cycle
// the result is registered, so no new request is taken before the last one
// is finished. The result waits in an output register until out_ready_i
// takes it, and the next request may be accepted meanwhile; a second
// finished result holds the sequencer, and with it the input, until that
// register drains. Table storage needs no clearing after reset: entries
// beyond the entry count are never read.
module address_blocklist_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [abt_pkg::OP_W-1:0]        operation_i,
  input  logic [abt_pkg::ADDR_W-1:0]      ip_address_i,
  input  logic                            permanent_flag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [abt_pkg::STATUS_W-1:0]    status_o,
  output logic [abt_pkg::SLOT_W-1:0]      slot_o,
  output logic [abt_pkg::HIT_W-1:0]       hit_total_o,
  output logic [abt_pkg::ECNT_W-1:0]      entry_count_o
);

  abt_pkg::req_t                  req;
  abt_pkg::res_t                  res;
  abt_pkg::ram_req_t              ram_req;
  logic [abt_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                           res_valid;
  logic                           res_take;

  logic                           out_valid_q, out_valid_d;
  abt_pkg::res_t                  out_q, out_d;

  // Pack the request fields for the sequencer.
  assign req.op   = abt_pkg::op_e'(operation_i);
  assign req.addr = ip_address_i;
  assign req.perm = permanent_flag_i;

  abt_ram #(
    .WIDTH (abt_pkg::ENTRY_W),
    .DEPTH (abt_pkg::TABLE_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  abt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Load a finished result whenever the output register is empty or drains now.
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign slot_o        = out_q.slot;
  assign hit_total_o   = out_q.hits;
  assign entry_count_o = out_q.entry_count;

endmodule

// ===== sim/address_blocklist_table_tb.sv =====
// Self-checking testbench of the blocked-address table, driven through its request handshake.
module address_blocklist_table_tb;

  // Longest stretch without any handshake before the run is declared hung:
  // covers a full-table scan, the long output hold-off and the idle bursts.
  localparam int QUIET_LIMIT   = 3000;
  // Cycles to let pass once nothing is pending.
  localparam int SETTLE_CYCLES = 140;
  localparam int STALL_LENGTH  = 300;
  localparam int POOL_SIZE     = 32;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_ready_o;
  logic [abt_pkg::OP_W-1:0]     operation_i      = '0;
  logic [abt_pkg::ADDR_W-1:0]   ip_address_i     = '0;
  logic                         permanent_flag_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i      = 1'b0;
  logic [abt_pkg::STATUS_W-1:0] status_o;
  logic [abt_pkg::SLOT_W-1:0]   slot_o;
  logic [abt_pkg::HIT_W-1:0]    hit_total_o;
  logic [abt_pkg::ECNT_W-1:0]   entry_count_o;

  address_blocklist_table dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .ip_address_i     (ip_address_i),
    .permanent_flag_i (permanent_flag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .hit_total_o      (hit_total_o),
    .entry_count_o    (entry_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the table, advanced once per accepted request.
  logic [abt_pkg::ADDR_W-1:0] shadow_addr [abt_pkg::TABLE_DEPTH];
  logic [abt_pkg::HIT_W-1:0]  shadow_hits [abt_pkg::TABLE_DEPTH];
  logic                       shadow_lock [abt_pkg::TABLE_DEPTH];
  int                         shadow_count = 0;

  // Outcomes predicted for accepted requests, oldest first.
  abt_pkg::res_t pending_outcomes [$];

  logic [abt_pkg::ADDR_W-1:0] address_pool [POOL_SIZE];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          idle_on        = 1'b1;
  int          stall_cycles   = 0;
  bit          stall_active   = 1'b0;

  // Scan the valid entries in order; the first match wins.
  function automatic bit find_entry(input logic [abt_pkg::ADDR_W-1:0] addr, output int pos);
    int i;
    pos = 0;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_addr[i] == addr) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow table and return the result it must produce.
  function automatic abt_pkg::res_t table_outcome(input abt_pkg::op_e op,
                                                  input logic [abt_pkg::ADDR_W-1:0] addr,
                                                  input logic perm);
    abt_pkg::res_t outcome;
    bit            hit;
    int            pos;
    int            j;
    outcome.status = abt_pkg::ST_NOT_FOUND;
    outcome.slot   = '0;
    outcome.hits   = '0;
    hit = 1'b0;
    pos = 0;
    // An unused operation code neither scans nor changes anything.
    if (op != abt_pkg::OP_NONE) hit = find_entry(addr, pos);
    // Block of a listed address and lookup both add one saturating hit;
    // the lock flag of a listed entry stays as it is.
    if (hit && (op == abt_pkg::OP_BLOCK || op == abt_pkg::OP_LOOKUP)) begin
      if (shadow_hits[pos] != '1) shadow_hits[pos] = shadow_hits[pos] + 1'b1;
      outcome.status = (op == abt_pkg::OP_BLOCK) ? abt_pkg::ST_PRESENT : abt_pkg::ST_FOUND;
      outcome.slot   = pos[abt_pkg::SLOT_W-1:0];
      outcome.hits   = shadow_hits[pos];
    end else if (op == abt_pkg::OP_BLOCK) begin
      if (shadow_count >= int'(abt_pkg::TABLE_DEPTH)) begin
        outcome.status = abt_pkg::ST_FULL;
      end else begin
        shadow_addr[shadow_count] = addr;
        shadow_hits[shadow_count] = abt_pkg::HIT_W'(1);
        shadow_lock[shadow_count] = perm;
        outcome.status = abt_pkg::ST_INSERTED;
        outcome.slot   = shadow_count[abt_pkg::SLOT_W-1:0];
        outcome.hits   = abt_pkg::HIT_W'(1);
        shadow_count++;
      end
    end else if (op == abt_pkg::OP_UNBLOCK && hit) begin
      outcome.slot = pos[abt_pkg::SLOT_W-1:0];
      outcome.hits = shadow_hits[pos];
      if (shadow_lock[pos]) begin
        outcome.status = abt_pkg::ST_REFUSED;
      end else begin
        // Close the gap: every later entry moves down one position.
        for (j = pos; j + 1 < shadow_count; j++) begin
          shadow_addr[j] = shadow_addr[j + 1];
          shadow_hits[j] = shadow_hits[j + 1];
          shadow_lock[j] = shadow_lock[j + 1];
        end
        shadow_count--;
        outcome.status = abt_pkg::ST_REMOVED;
      end
    end
    outcome.entry_count = shadow_count[abt_pkg::ECNT_W-1:0];
    return outcome;
  endfunction

  task automatic report_mismatch(input string what, input logic [abt_pkg::HIT_W-1:0] got,
                                 input logic [abt_pkg::HIT_W-1:0] want);
    mismatch_count++;
    $display("%0t: %0s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Offer one request, hold it until accepted, then record its predicted result.
  // Valid is left high on return so back-to-back requests drop it only for an idle burst.
  task automatic send_request(input abt_pkg::op_e op, input logic [abt_pkg::ADDR_W-1:0] addr,
                              input logic perm);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    ip_address_i     <= addr;
    permanent_flag_i <= perm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_outcomes.push_back(table_outcome(op, addr, perm));
  endtask

  // Stop offering and wait until every predicted result has been taken,
  // then let the block settle.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Hand-picked sequence: empty-table misses, the unused code, perm ignored on
  // a listed address, refusal of a permanent entry, removal with shift.
  task automatic test_directed_cases();
    send_request(abt_pkg::OP_LOOKUP,  32'hC0A8_0001, 1'b0);
    send_request(abt_pkg::OP_UNBLOCK, 32'hC0A8_0001, 1'b1);
    send_request(abt_pkg::OP_NONE,    32'hFFFF_FFFF, 1'b1);
    send_request(abt_pkg::OP_BLOCK,   32'h0000_0000, 1'b1);
    send_request(abt_pkg::OP_BLOCK,   32'hFFFF_FFFF, 1'b0);
    send_request(abt_pkg::OP_BLOCK,   32'hC0A8_0001, 1'b0);
    send_request(abt_pkg::OP_BLOCK,   32'h0A00_0001, 1'b0);
    send_request(abt_pkg::OP_BLOCK,   32'hFFFF_FFFF, 1'b1);
    send_request(abt_pkg::OP_LOOKUP,  32'h0000_0000, 1'b0);
    send_request(abt_pkg::OP_LOOKUP,  32'hFFFF_FFFF, 1'b1);
    send_request(abt_pkg::OP_LOOKUP,  32'h7FFF_FFFF, 1'b0);
    send_request(abt_pkg::OP_UNBLOCK, 32'h0000_0000, 1'b0);
    send_request(abt_pkg::OP_UNBLOCK, 32'hFFFF_FFFF, 1'b0);
    send_request(abt_pkg::OP_LOOKUP,  32'h0A00_0001, 1'b0);
    send_request(abt_pkg::OP_NONE,    32'h0A00_0001, 1'b0);
    send_request(abt_pkg::OP_UNBLOCK, 32'h0A00_0001, 1'b0);
    send_request(abt_pkg::OP_UNBLOCK, 32'h0A00_0001, 1'b0);
    send_request(abt_pkg::OP_BLOCK,   32'h8000_0000, 1'b1);
    send_request(abt_pkg::OP_BLOCK,   32'h5555_5555, 1'b0);
    send_request(abt_pkg::OP_BLOCK,   32'hAAAA_AAAA, 1'b0);
    send_request(abt_pkg::OP_UNBLOCK, 32'hC0A8_0001, 1'b0);
  endtask

  // Fill every slot, probe the full table at its deepest position, remove the
  // lowest removable entry for the longest shift, then drain back down.
  task automatic test_fill_and_drain();
    logic [abt_pkg::ADDR_W-1:0] addr;
    int pos;
    int i;
    int start;
    int attempts;
    while (shadow_count < int'(abt_pkg::TABLE_DEPTH)) begin
      addr = $urandom();
      if (!find_entry(addr, pos))
        send_request(abt_pkg::OP_BLOCK, addr, (shadow_count % 40) == 7);
    end
    addr = $urandom();
    while (find_entry(addr, pos)) addr = $urandom();
    send_request(abt_pkg::OP_BLOCK,  addr, 1'b0);
    send_request(abt_pkg::OP_BLOCK,  shadow_addr[abt_pkg::TABLE_DEPTH-1], 1'b1);
    send_request(abt_pkg::OP_LOOKUP, shadow_addr[abt_pkg::TABLE_DEPTH-1], 1'b0);
    send_request(abt_pkg::OP_LOOKUP, addr, 1'b0);
    send_request(abt_pkg::OP_NONE,   addr, 1'b1);
    pos = -1;
    for (i = 0; i < shadow_count; i++) if (pos < 0 && !shadow_lock[i]) pos = i;
    if (pos >= 0) send_request(abt_pkg::OP_UNBLOCK, shadow_addr[pos], 1'b0);
    // Drop random removable entries; permanent ones stay behind.
    attempts = 0;
    while (shadow_count > 12 && attempts < 400) begin
      start = $urandom_range(0, shadow_count - 1);
      pos = -1;
      for (i = 0; i < shadow_count; i++)
        if (pos < 0 && !shadow_lock[(start + i) % shadow_count])
          pos = (start + i) % shadow_count;
      if (pos < 0) break;
      send_request(abt_pkg::OP_UNBLOCK, shadow_addr[pos], 1'($urandom_range(0, 1)));
      attempts++;
    end
  endtask

  // Hold the result side off while requests keep coming, so the output
  // register fills and the block has to stall its input.
  task automatic test_output_backpressure();
    int k;
    idle_on = 1'b0;
    stall_cycles = STALL_LENGTH;
    while (!stall_active) @(posedge clk_i);
    for (k = 0; k < 8; k++) begin
      if (k % 2 == 0)
        send_request(abt_pkg::OP_LOOKUP,
                     shadow_addr[$urandom_range(0, shadow_count - 1)], 1'b0);
      else
        send_request(abt_pkg::OP_BLOCK, $urandom(), 1'b0);
    end
    idle_on = 1'b1;
  endtask

  // Mostly addresses already listed or from a small pool so that matches,
  // refusals and removals are common; the rest are fully random addresses.
  task automatic test_random_traffic(input int count);
    int k;
    int roll;
    int pick;
    abt_pkg::op_e op;
    logic [abt_pkg::ADDR_W-1:0] addr;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      // Lean toward removal when the table runs high so it keeps moving.
      if (shadow_count >= 100)
        op = (roll < 25) ? abt_pkg::OP_BLOCK :
             (roll < 50) ? abt_pkg::OP_LOOKUP :
             (roll < 95) ? abt_pkg::OP_UNBLOCK : abt_pkg::OP_NONE;
      else
        op = (roll < 40) ? abt_pkg::OP_BLOCK :
             (roll < 70) ? abt_pkg::OP_LOOKUP :
             (roll < 95) ? abt_pkg::OP_UNBLOCK : abt_pkg::OP_NONE;
      pick = $urandom_range(0, 99);
      if (shadow_count > 0 && pick < 55) addr = shadow_addr[$urandom_range(0, shadow_count - 1)];
      else if (pick < 85) addr = address_pool[$urandom_range(0, POOL_SIZE - 1)];
      else addr = $urandom();
      send_request(op, addr, $urandom_range(0, 99) < 5);
    end
  endtask

  // Result side: hold off on request, idle in random bursts, else take results.
  initial begin : result_sink
    @(posedge clk_i);
    forever begin
      if (stall_cycles != 0) begin
        out_ready_i <= 1'b0;
        stall_active = 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
        stall_cycles = 0;
        stall_active = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest prediction, field by field.
  always @(posedge clk_i) begin
    abt_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unrequested result status", abt_pkg::HIT_W'(status_o), '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", abt_pkg::HIT_W'(status_o), abt_pkg::HIT_W'(want.status));
        if (slot_o !== want.slot)
          report_mismatch("slot", abt_pkg::HIT_W'(slot_o), abt_pkg::HIT_W'(want.slot));
        if (hit_total_o !== want.hits)
          report_mismatch("hit_total", hit_total_o, want.hits);
        if (entry_count_o !== want.entry_count)
          report_mismatch("entry_count", abt_pkg::HIT_W'(entry_count_o),
                          abt_pkg::HIT_W'(want.entry_count));
      end
    end
  end

  // Declare the run hung when no handshake happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    foreach (address_pool[n]) address_pool[n] = $urandom();
    address_pool[0] = '0;
    address_pool[1] = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    wait_until_drained();
    test_fill_and_drain();
    wait_until_drained();
    test_output_backpressure();
    wait_until_drained();
    test_random_traffic(900);
    // Finish with both sides running flat out.
    idle_on = 1'b0;
    test_random_traffic(380);
    wait_until_drained();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
